### src/clcd_pkg.sv
// Shared types and constants for the character-LCD transfer formatter.
`default_nettype none
package clcd_pkg;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_CURSOR = 2'd2,
    KIND_NUMBER = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MUL,
    FS_DIV,
    FS_EMIT
  } front_state_t;

  // one byte queued for the bus side
  typedef struct packed {
    logic [7:0] data;
    logic       rs;
    logic       last;
  } byte_entry_t;

  localparam logic [7:0]  CURSOR_ROW1  = 8'h80;
  localparam logic [7:0]  CURSOR_ROW2  = 8'hC0;
  localparam logic [7:0]  ASCII_ZERO   = 8'h30;
  localparam int          DIGIT_CAP    = 10;
  // floor(x/10) = (x * RECIP) >> 35 for any 32-bit x
  localparam logic [31:0] DIV10_RECIP  = 32'hCCCCCCCD;
  localparam int          DIV10_SHIFT  = 35;
  localparam logic        CFG_SEL_FOUR = 1'b0;
  localparam logic        RS_COMMAND   = 1'b0;
  localparam logic        RS_DATA      = 1'b1;

endpackage
`default_nettype wire

### src/clcd_fifo.sv
// Small register queue between the request front end and the bus back end.
`default_nettype none
module clcd_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire clcd_pkg::byte_entry_t push_entry,
  output logic                      full,
  input  wire logic                 pop,
  output clcd_pkg::byte_entry_t     pop_entry,
  output logic                      not_empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  clcd_pkg::byte_entry_t mem_r [DEPTH];
  logic [PTRW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CNTW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

### src/clcd_front.sv
// Request front end: classifies requests, converts numbers to digits, queues bytes.
`default_nettype none
module clcd_front #(
  parameter int MAX_DIGITS   = 10,
  parameter int LINE_COLUMNS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  input  wire clcd_pkg::kind_t       req_kind,
  input  wire logic [7:0]            req_byte,
  input  wire logic [1:0]            req_row,
  input  wire logic [4:0]            req_column,
  input  wire logic [31:0]           req_number,
  output logic                       q_push,
  output clcd_pkg::byte_entry_t      q_entry,
  input  wire logic                  q_full
);

  localparam int CAP  = (MAX_DIGITS < clcd_pkg::DIGIT_CAP) ? MAX_DIGITS : clcd_pkg::DIGIT_CAP;
  localparam int IDXW = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int QW   = 64 - clcd_pkg::DIV10_SHIFT;

  clcd_pkg::front_state_t state_r, state_nxt;
  logic [31:0]     cur_r, cur_nxt;
  logic [63:0]     prod_r;
  logic [3:0]      digit_count_r, digit_count_nxt;
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic [3:0]      digit_store_r [CAP];
  logic            store_we;
  logic [IDXW-1:0] store_addr;
  logic [3:0]      store_data;

  logic [QW-1:0]   quot;
  logic [31:0]     quot_x10;
  logic [31:0]     diff;
  logic            in_range;
  logic [7:0]      cursor_cmd;

  assign quot     = prod_r[63:clcd_pkg::DIV10_SHIFT];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign diff     = cur_r - quot_x10;

  always_comb begin
    in_range = (req_row == 2'd1 || req_row == 2'd2) && (req_column != 5'd0)
               && (32'(req_column) <= LINE_COLUMNS);
    if (!in_range) begin
      cursor_cmd = clcd_pkg::CURSOR_ROW1;
    end else if (req_row == 2'd1) begin
      cursor_cmd = clcd_pkg::CURSOR_ROW1 + {3'b000, req_column} - 8'd1;
    end else begin
      cursor_cmd = clcd_pkg::CURSOR_ROW2 + {3'b000, req_column} - 8'd1;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    digit_count_nxt = digit_count_r;
    idx_nxt         = idx_r;
    req_ready       = 1'b0;
    q_push          = 1'b0;
    q_entry         = '0;
    store_we        = 1'b0;
    store_addr      = digit_count_r[IDXW-1:0];
    store_data      = diff[3:0];
    unique case (state_r)
      clcd_pkg::FS_IDLE: begin
        req_ready = !q_full;
        if (req_valid && !q_full) begin
          unique case (req_kind)
            clcd_pkg::KIND_CMD: begin
              q_push  = 1'b1;
              q_entry = '{data: req_byte, rs: clcd_pkg::RS_COMMAND, last: 1'b1};
            end
            clcd_pkg::KIND_CHAR: begin
              q_push  = 1'b1;
              q_entry = '{data: req_byte, rs: clcd_pkg::RS_DATA, last: 1'b1};
            end
            clcd_pkg::KIND_CURSOR: begin
              q_push  = 1'b1;
              q_entry = '{data: cursor_cmd, rs: clcd_pkg::RS_COMMAND, last: 1'b1};
            end
            clcd_pkg::KIND_NUMBER: begin
              cur_nxt = req_number;
              if (req_number == 32'd0) begin
                store_we        = 1'b1;
                store_addr      = '0;
                store_data      = 4'd0;
                digit_count_nxt = 4'd1;
                idx_nxt         = '0;
                state_nxt       = clcd_pkg::FS_EMIT;
              end else begin
                digit_count_nxt = 4'd0;
                state_nxt       = clcd_pkg::FS_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      clcd_pkg::FS_MUL: begin
        state_nxt = clcd_pkg::FS_DIV;
      end
      clcd_pkg::FS_DIV: begin
        store_we        = 1'b1;
        digit_count_nxt = digit_count_r + 4'd1;
        cur_nxt         = 32'(quot);
        if (quot == '0 || digit_count_nxt == 4'(CAP)) begin
          idx_nxt   = digit_count_r[IDXW-1:0];
          state_nxt = clcd_pkg::FS_EMIT;
        end else begin
          state_nxt = clcd_pkg::FS_MUL;
        end
      end
      clcd_pkg::FS_EMIT: begin
        if (!q_full) begin
          q_push  = 1'b1;
          q_entry = '{data: clcd_pkg::ASCII_ZERO + {4'b0000, digit_store_r[idx_r]},
                      rs: clcd_pkg::RS_DATA, last: (idx_r == '0)};
          if (idx_r == '0) begin
            state_nxt = clcd_pkg::FS_IDLE;
          end else begin
            idx_nxt = idx_r - IDXW'(1);
          end
        end
      end
      default: state_nxt = clcd_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= clcd_pkg::FS_IDLE;
      digit_count_r <= 4'd0;
    end else begin
      state_r       <= state_nxt;
      digit_count_r <= digit_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    prod_r <= 64'(cur_r) * 64'(clcd_pkg::DIV10_RECIP);
    if (store_we) begin
      digit_store_r[store_addr] <= store_data;
    end
  end

endmodule
`default_nettype wire

### src/clcd_back.sv
// Bus back end: splits queued bytes into nibble or byte transfers on the output register.
`default_nettype none
module clcd_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  four_bit_bus,
  input  wire logic                  q_not_empty,
  input  wire clcd_pkg::byte_entry_t q_entry,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_value,
  output logic                       out_rs,
  output logic                       out_last
);

  logic                  valid_r, valid_nxt;
  logic                  low_pending_r, low_pending_nxt;
  clcd_pkg::byte_entry_t held_r, held_nxt;
  logic [7:0]            value_r, value_nxt;
  logic                  rs_r, rs_nxt;
  logic                  last_r, last_nxt;
  logic                  load;

  assign load      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_value = value_r;
  assign out_rs    = rs_r;
  assign out_last  = last_r;

  always_comb begin
    valid_nxt       = valid_r;
    low_pending_nxt = low_pending_r;
    held_nxt        = held_r;
    value_nxt       = value_r;
    rs_nxt          = rs_r;
    last_nxt        = last_r;
    q_pop           = 1'b0;
    if (load) begin
      if (low_pending_r) begin
        valid_nxt       = 1'b1;
        value_nxt       = {4'h0, held_r.data[3:0]};
        rs_nxt          = held_r.rs;
        last_nxt        = held_r.last;
        low_pending_nxt = 1'b0;
      end else if (q_not_empty) begin
        q_pop     = 1'b1;
        valid_nxt = 1'b1;
        rs_nxt    = q_entry.rs;
        held_nxt  = q_entry;
        if (four_bit_bus) begin
          value_nxt       = {4'h0, q_entry.data[7:4]};
          last_nxt        = 1'b0;
          low_pending_nxt = 1'b1;
        end else begin
          value_nxt = q_entry.data;
          last_nxt  = q_entry.last;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= 1'b0;
      low_pending_r <= 1'b0;
    end else begin
      valid_r       <= valid_nxt;
      low_pending_r <= low_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r  <= held_nxt;
    value_r <= value_nxt;
    rs_r    <= rs_nxt;
    last_r  <= last_nxt;
  end

endmodule
`default_nettype wire

### src/char_lcd_transfer_formatter.sv
// Top level of the character-LCD transfer formatter.
//
//   port group  direction  role
//   in_*        slave      requests: tuser kind, tdata byte/row/column/number
//   out_*       master     bus transfers: tdata value, tuser register select, tlast
//   cfg_*       APB slave  register four_bit_bus at byte address 0
//
// Command, character and cursor requests are taken one a cycle while the queue has room.
// A number is worked in a divide-by-ten loop, each digit taking a reciprocal multiply step
// and then a subtract step; its digits, up to 10, are then queued most significant first.
// The back end sends one transfer per cycle from its output register while out_tready is
// high; in_tready drops while a number is worked or the queue is full.
// Reset is synchronous, rst_n low.
`default_nettype none
module char_lcd_transfer_formatter #(
  parameter int MAX_DIGITS   = 10,
  parameter int LINE_COLUMNS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] byte_value, [9:8] row, [14:10] column, [46:15] number, [47] zero
  input  wire logic [47:0] in_tdata,
  // [1:0] kind
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] bus_value
  output logic [7:0]       out_tdata,
  // [0] register_select
  output logic [0:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic                  four_bit_r;
  logic                  cfg_write;
  logic                  q_push, q_full, q_pop, q_not_empty;
  clcd_pkg::byte_entry_t q_in, q_out;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == clcd_pkg::CFG_SEL_FOUR);
  assign cfg_prdata = (cfg_paddr[2] == clcd_pkg::CFG_SEL_FOUR) ? {31'd0, four_bit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_r <= 1'b1;
    end else if (cfg_write) begin
      four_bit_r <= cfg_pwdata[0];
    end
  end

  clcd_front #(
    .MAX_DIGITS   (MAX_DIGITS),
    .LINE_COLUMNS (LINE_COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_kind   (clcd_pkg::kind_t'(in_tuser)),
    .req_byte   (in_tdata[7:0]),
    .req_row    (in_tdata[9:8]),
    .req_column (in_tdata[14:10]),
    .req_number (in_tdata[46:15]),
    .q_push     (q_push),
    .q_entry    (q_in),
    .q_full     (q_full)
  );

  clcd_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_out),
    .not_empty  (q_not_empty)
  );

  clcd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .four_bit_bus (four_bit_r),
    .q_not_empty  (q_not_empty),
    .q_entry      (q_out),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_value    (out_tdata),
    .out_rs       (out_tuser[0]),
    .out_last     (out_tlast)
  );

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the character-LCD transfer formatter.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_DIGITS    = 10;
  localparam int          LINE_COLUMNS  = 16;
  localparam logic [2:0]  ADDR_FOUR_BIT = 3'd0;
  localparam int          SEG_ITEMS     = 45;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          DRAIN_CYCLES  = 60;
  localparam int          CYCLE_LIMIT   = 400000;

  typedef struct {
    clcd_pkg::kind_t kind;
    logic [7:0]      byte_value;
    logic [1:0]      row;
    logic [4:0]      column;
    logic [31:0]     number;
  } lcd_req_t;

  typedef struct {
    logic [7:0] value;
    logic       rs;
    logic       last;
  } lcd_xfer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  char_lcd_transfer_formatter #(
    .MAX_DIGITS  (MAX_DIGITS),
    .LINE_COLUMNS(LINE_COLUMNS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  lcd_req_t  pend_q[$];
  lcd_xfer_t xfer_q[$];
  lcd_req_t  cur_req;

  logic        exp_nibble_bus = 1'b1;
  logic [3:0]  digit_store [MAX_DIGITS];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_used = 1'b0;
  int          hold_left = 0;
  int          req_accepted = 0;
  int          num_accepted = 0;
  int          cursor_accepted = 0;
  int          xfer_checked = 0;
  int          mismatch_count = 0;
  int          cycles = 0;

  function automatic void push_byte(logic [7:0] b, logic rs, logic fin);
    if (exp_nibble_bus) begin
      xfer_q.push_back('{value: {4'h0, b[7:4]}, rs: rs, last: 1'b0});
      xfer_q.push_back('{value: {4'h0, b[3:0]}, rs: rs, last: fin});
    end else begin
      xfer_q.push_back('{value: b, rs: rs, last: fin});
    end
  endfunction

  function automatic void expand_request(lcd_req_t r);
    logic [7:0]  cmd;
    logic [31:0] n;
    int          cap;
    int          cnt;
    cap = (MAX_DIGITS < clcd_pkg::DIGIT_CAP) ? MAX_DIGITS : clcd_pkg::DIGIT_CAP;
    case (r.kind)
      clcd_pkg::KIND_CMD:  push_byte(r.byte_value, clcd_pkg::RS_COMMAND, 1'b1);
      clcd_pkg::KIND_CHAR: push_byte(r.byte_value, clcd_pkg::RS_DATA, 1'b1);
      clcd_pkg::KIND_CURSOR: begin
        if (r.row < 1 || r.row > 2 || r.column < 1 || r.column > LINE_COLUMNS)
          cmd = clcd_pkg::CURSOR_ROW1;
        else if (r.row == 1)
          cmd = clcd_pkg::CURSOR_ROW1 + {3'b0, r.column} - 8'd1;
        else
          cmd = clcd_pkg::CURSOR_ROW2 + {3'b0, r.column} - 8'd1;
        push_byte(cmd, clcd_pkg::RS_COMMAND, 1'b1);
      end
      default: begin
        n = r.number;
        cnt = 0;
        if (n == 0) begin
          digit_store[0] = 4'd0;
          cnt = 1;
        end else begin
          while (n != 0 && cnt < cap) begin
            digit_store[cnt] = 4'(n % 10);
            n = n / 10;
            cnt++;
          end
        end
        while (cnt > 0) begin
          cnt--;
          push_byte(clcd_pkg::ASCII_ZERO + {4'h0, digit_store[cnt]}, clcd_pkg::RS_DATA,
                    cnt == 0);
        end
      end
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expand_request(cur_req);
        req_accepted++;
        if (cur_req.kind == clcd_pkg::KIND_NUMBER) num_accepted++;
        if (cur_req.kind == clcd_pkg::KIND_CURSOR) cursor_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pend_q.pop_front();
          in_tdata <= {1'b0, cur_req.number, cur_req.column, cur_req.row, cur_req.byte_value};
          in_tuser <= cur_req.kind;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with a single long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    lcd_xfer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (xfer_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transfer: value %h rs %b last %b",
                   out_tdata, out_tuser[0], out_tlast);
      end else begin
        want = xfer_q.pop_front();
        xfer_checked++;
        if (out_tdata !== want.value || out_tuser[0] !== want.rs || out_tlast !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("transfer %0d: expected value %h rs %b last %b, got value %h rs %b last %b",
                     xfer_checked, want.value, want.rs, want.last,
                     out_tdata, out_tuser[0], out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_req(clcd_pkg::kind_t k, logic [7:0] b, logic [1:0] r, logic [4:0] c,
                           logic [31:0] n);
    pend_q.push_back('{kind: k, byte_value: b, row: r, column: c, number: n});
  endtask

  function automatic logic [31:0] pick_number();
    longint unsigned lo;
    longint unsigned hi;
    int              sel;
    int              digits;
    sel = $urandom_range(99);
    if (sel < 8) return 32'd0;
    if (sel < 13) return 32'hFFFF_FFFF;
    if (sel < 25) return $urandom();
    digits = $urandom_range(1, 10);
    lo = 1;
    repeat (digits - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return 32'(lo + ({$urandom(), $urandom()} % (hi - lo + 1)));
  endfunction

  task automatic queue_random_req();
    clcd_pkg::kind_t k;
    logic [1:0]      r;
    logic [4:0]      c;
    k = clcd_pkg::kind_t'($urandom_range(3));
    r = 2'($urandom());
    c = 5'($urandom());
    if (k == clcd_pkg::KIND_CURSOR && $urandom_range(99) < 70) begin
      r = 2'($urandom_range(1, 2));
      c = 5'($urandom_range(1, LINE_COLUMNS));
    end
    queue_req(k, 8'($urandom()), r, c, pick_number());
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || in_tvalid || xfer_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_bus_mode(logic four);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_FOUR_BIT;
    cfg_pwdata <= {31'($urandom()), four};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    exp_nibble_bus <= four;
    @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, four-bit bus after reset
    queue_req(clcd_pkg::KIND_CMD,    8'h00, 2'd0, 5'd0,  32'd0);
    queue_req(clcd_pkg::KIND_CMD,    8'hFF, 2'd3, 5'd31, 32'hFFFF_FFFF);
    queue_req(clcd_pkg::KIND_CHAR,   8'h00, 2'd0, 5'd0,  32'd0);
    queue_req(clcd_pkg::KIND_CHAR,   8'hFF, 2'd3, 5'd31, 32'hFFFF_FFFF);
    queue_req(clcd_pkg::KIND_CHAR,   8'hA5, 2'd1, 5'd5,  32'd7);
    queue_req(clcd_pkg::KIND_CURSOR, 8'h00, 2'd1, 5'd1,  32'd0);
    queue_req(clcd_pkg::KIND_CURSOR, 8'h00, 2'd1, 5'd16, 32'd0);
    queue_req(clcd_pkg::KIND_CURSOR, 8'h00, 2'd2, 5'd1,  32'd0);
    queue_req(clcd_pkg::KIND_CURSOR, 8'h00, 2'd2, 5'd16, 32'd0);
    queue_req(clcd_pkg::KIND_CURSOR, 8'hFF, 2'd0, 5'd5,  32'd0);
    queue_req(clcd_pkg::KIND_CURSOR, 8'hFF, 2'd3, 5'd5,  32'd0);
    queue_req(clcd_pkg::KIND_CURSOR, 8'hFF, 2'd1, 5'd0,  32'd0);
    queue_req(clcd_pkg::KIND_CURSOR, 8'hFF, 2'd2, 5'd17, 32'd0);
    queue_req(clcd_pkg::KIND_CURSOR, 8'hFF, 2'd1, 5'd31, 32'd0);
    queue_req(clcd_pkg::KIND_NUMBER, 8'hFF, 2'd3, 5'd31, 32'd0);
    queue_req(clcd_pkg::KIND_NUMBER, 8'h00, 2'd0, 5'd0,  32'd9);
    queue_req(clcd_pkg::KIND_NUMBER, 8'h00, 2'd0, 5'd0,  32'd10);
    queue_req(clcd_pkg::KIND_NUMBER, 8'h00, 2'd0, 5'd0,  32'd1_000_000_000);
    queue_req(clcd_pkg::KIND_NUMBER, 8'h00, 2'd0, 5'd0,  32'hFFFF_FFFF);
    wait_drained();

    // directed, eight-bit bus
    write_bus_mode(1'b0);
    queue_req(clcd_pkg::KIND_CMD,    8'hFF, 2'd0, 5'd0,  32'd0);
    queue_req(clcd_pkg::KIND_CHAR,   8'hA5, 2'd0, 5'd0,  32'd0);
    queue_req(clcd_pkg::KIND_CURSOR, 8'h00, 2'd2, 5'd16, 32'd0);
    queue_req(clcd_pkg::KIND_CURSOR, 8'h00, 2'd3, 5'd20, 32'd0);
    queue_req(clcd_pkg::KIND_NUMBER, 8'h00, 2'd0, 5'd0,  32'd0);
    queue_req(clcd_pkg::KIND_NUMBER, 8'h00, 2'd0, 5'd0,  32'hFFFF_FFFF);
    wait_drained();

    // random segments: both bus widths under each idle pattern
    for (int seg = 0; seg < 8; seg++) begin
      write_bus_mode(seg[0]);
      case (seg / 2)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 47; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 47; end
        default: begin send_idle_pct <= 29; recv_stall_pct <= 29; end
      endcase
      if (seg == 1) hold_req <= 1'b1;
      repeat (SEG_ITEMS) queue_random_req();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests (%0d numbers, %0d cursor moves) checked as %0d bus transfers",
             req_accepted, num_accepted, cursor_accepted, xfer_checked);
    $display("both bus widths, four idle patterns and one long output hold-off; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && xfer_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
